// File: design/sfw_pkg.sv
// ----------------------------------------------------------------------------
// sfw_pkg
// Shared types and constants of the vorticity/divergence to wind converter.
// ----------------------------------------------------------------------------
package sfw_pkg;

   localparam int MAX_TRUNC_DEF = 127;
   localparam int COEF_BITS_DEF = 32;

   localparam int IDX_W  = 7;
   localparam int DATA_W = 32;
   localparam int OUT_W  = 48;
   localparam int RAD_W  = 24;
   localparam int RAD_BIT_W = $clog2(RAD_W);
   localparam int CSR_IDX_W = 1;

   localparam logic [IDX_W-1:0] TRUNC_RESET  = 7'd63;
   localparam logic [RAD_W-1:0] RADIUS_RESET = 24'd6371229;

   // job queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QLVL_W = $clog2(QDEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRUNC  = 1'b0,
      CSR_RADIUS = 1'b1
   } csr_index_type;

   typedef enum logic {
      COEF_D = 1'b0,
      COEF_S = 1'b1
   } coef_kind_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] vort_re;
      logic signed [DATA_W-1:0] vort_im;
      logic signed [DATA_W-1:0] div_re;
      logic signed [DATA_W-1:0] div_im;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] u_re;
      logic signed [OUT_W-1:0] u_im;
      logic signed [OUT_W-1:0] v_re;
      logic signed [OUT_W-1:0] v_im;
      logic [IDX_W-1:0]        zonal_index;
      logic [IDX_W-1:0]        total_index;
      logic                    run_last;
   } rsp_type;

   // one accepted input with its neighbours, as handed to the back end
   typedef struct packed {
      logic [IDX_W-1:0] m;
      logic [IDX_W-1:0] n;
      logic [IDX_W-1:0] t;
      req_type          cur;
      req_type          p1;
      req_type          p2;
      logic             emit_prev;
      logic             row_end;
      logic             zero_row;
   } job_type;

   typedef struct packed {
      logic             start;
      coef_kind_type    kind;
      logic [IDX_W-1:0] m;
      logic [IDX_W:0]   n;
   } coef_req_type;

endpackage

// File: design/sfw_front.sv
// ----------------------------------------------------------------------------
// sfw_front
// Tracks (m,n) of the incoming coefficient, keeps the two-deep neighbour
// window and pushes one job per accepted beat into the queue.
// ----------------------------------------------------------------------------
module sfw_front #(
   parameter int MAX_TRUNC = sfw_pkg::MAX_TRUNC_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     restart,
   input  logic [sfw_pkg::IDX_W-1:0] trunc,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sfw_pkg::req_type         req_data,
   input  logic                     q_full,
   output logic                     push,
   output sfw_pkg::job_type         job
);
   import sfw_pkg::*;

   localparam logic [IDX_W:0] MAXT = (IDX_W+1)'(MAX_TRUNC);

   logic [IDX_W-1:0] zc_ff, zc_in, tc_ff, tc_in;
   req_type          w0_ff, w0_in, w1_ff, w1_in;
   logic [IDX_W-1:0] t, tm1, m, n;
   logic             bad;

   always_comb begin
      if (trunc < IDX_W'(2)) begin
         t = IDX_W'(2);
      end else if ({1'b0, trunc} > MAXT) begin
         t = MAXT[IDX_W-1:0];
      end else begin
         t = trunc;
      end
      tm1 = t - IDX_W'(1);
      // position outside the field restarts at (0,0)
      bad = (zc_ff > tm1) || (tc_ff > tm1) || (tc_ff < zc_ff);
      m   = bad ? '0 : zc_ff;
      n   = bad ? '0 : tc_ff;

      job.m         = m;
      job.n         = n;
      job.t         = t;
      job.cur       = req_data;
      job.p1        = (n > m) ? w0_ff : '0;
      job.p2        = ({1'b0, n} > ({1'b0, m} + (IDX_W+1)'(1))) ? w1_ff : '0;
      job.emit_prev = n > m;
      job.row_end   = n == tm1;
      job.zero_row  = m == tm1;

      req_ready = !q_full;
      push      = req_valid && !q_full;

      w1_in = bad ? '0 : w0_ff;
      w0_in = req_data;
      if (n == tm1) begin
         zc_in = (m == tm1) ? '0 : m + IDX_W'(1);
         tc_in = zc_in;
      end else begin
         zc_in = m;
         tc_in = n + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         zc_ff <= '0;
         tc_ff <= '0;
         w0_ff <= '0;
         w1_ff <= '0;
      end else if (push) begin
         zc_ff <= zc_in;
         tc_ff <= tc_in;
         w0_ff <= w0_in;
         w1_ff <= w1_in;
      end
   end

endmodule

// File: design/sfw_queue.sv
// ----------------------------------------------------------------------------
// sfw_queue
// Short job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module sfw_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sfw_pkg::job_type           job_in,
   input  logic                       pop,
   output logic                       full,
   output logic                       valid,
   output sfw_pkg::job_type           head,
   output logic [sfw_pkg::QLVL_W-1:0] level
);
   import sfw_pkg::*;

   job_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QLVL_W-1:0] level_ff;

   assign full  = level_ff == QLVL_W'(QDEPTH);
   assign valid = level_ff != '0;
   assign head  = mem_ff[rd_ptr_ff];
   assign level = level_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + QLVL_W'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - QLVL_W'(1);
         end
      end
   end

endmodule

// File: design/sfw_coef.sv
// ----------------------------------------------------------------------------
// sfw_coef
// Computes d(m,n) or s(m,n) on request: a radix-2 restoring divider shared by
// both, followed for d by a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module sfw_coef #(
   parameter int COEF_BITS = sfw_pkg::COEF_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sfw_pkg::coef_req_type       req,
   output logic                        done,
   output logic signed [COEF_BITS:0]   value
);
   import sfw_pkg::*;

   localparam int CW   = COEF_BITS + 1;
   localparam int NW   = 2 * COEF_BITS + 18;
   localparam int DW   = 30;
   localparam int SW   = 2 * COEF_BITS + 2;
   localparam int RTW  = COEF_BITS + 1;
   localparam int RW   = COEF_BITS + 4;
   localparam int CNTW = $clog2(NW + 1);

   typedef enum logic [2:0] {C_IDLE, C_PREP, C_PREP2, C_DIV, C_SQRT} state_type;

   state_type          state_ff;
   coef_kind_type      kind_ff;
   logic [IDX_W-1:0]   m_ff;
   logic [IDX_W:0]     n_ff;
   logic [15:0]        nsq_ff, nn1_ff;
   logic [13:0]        msq_ff;
   logic [NW-1:0]      num_ff, quo_ff;
   logic [DW-1:0]      den_ff, rem_ff;
   logic [CNTW-1:0]    cnt_ff;
   logic [SW-1:0]      src_ff;
   logic [RW-1:0]      srem_ff;
   logic [RTW-1:0]     root_ff;
   logic               done_ff;
   logic signed [CW-1:0] value_ff;

   logic               zero_req;
   logic [DW:0]        r2;
   logic               ge;
   logic [DW-1:0]      rem_in;
   logic [RW-1:0]      sr_n, trial;
   logic               sge;
   logic [17:0]        q4, b4;
   logic [33:0]        a_full;
   logic [RTW:0]       rp1;

   assign done  = done_ff;
   assign value = value_ff;

   always_comb begin
      if (req.kind == COEF_D) begin
         zero_req = (req.n == '0) || (req.n <= {1'b0, req.m});
      end else begin
         zero_req = (req.m == '0) || (req.n == '0);
      end
      // (4n^2-1)n^2 and 4(n^2-m^2)
      q4     = {nsq_ff, 2'b00} - 18'd1;
      a_full = 34'(q4) * 34'(nsq_ff);
      b4     = {nsq_ff - {2'b00, msq_ff}, 2'b00};
      // divider step
      r2     = {rem_ff, num_ff[NW-1]};
      ge     = r2 >= {1'b0, den_ff};
      rem_in = ge ? DW'(r2 - {1'b0, den_ff}) : r2[DW-1:0];
      // square root step, two radicand bits per cycle
      sr_n   = {srem_ff[RW-3:0], src_ff[SW-1:SW-2]};
      trial  = {{(RW-RTW-2){1'b0}}, root_ff, 2'b01};
      sge    = sr_n >= trial;
      // round root/2 to nearest
      rp1    = {1'b0, root_ff} + {{RTW{1'b0}}, 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            C_IDLE: begin
               if (req.start) begin
                  kind_ff <= req.kind;
                  m_ff    <= req.m;
                  n_ff    <= req.n;
                  if (zero_req) begin
                     value_ff <= '0;
                     done_ff  <= 1'b1;
                  end else begin
                     state_ff <= C_PREP;
                  end
               end
            end
            C_PREP: begin
               nsq_ff   <= 16'(n_ff) * 16'(n_ff);
               msq_ff   <= 14'(m_ff) * 14'(m_ff);
               nn1_ff   <= 16'(n_ff) * (16'(n_ff) + 16'd1);
               state_ff <= C_PREP2;
            end
            C_PREP2: begin
               if (kind_ff == COEF_D) begin
                  den_ff <= a_full[DW-1:0];
                  num_ff <= NW'(b4) << (2 * COEF_BITS);
               end else begin
                  den_ff <= DW'(nn1_ff);
                  num_ff <= (NW'(m_ff) << COEF_BITS) + NW'(nn1_ff[15:1]);
               end
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= C_DIV;
            end
            C_DIV: begin
               if (cnt_ff == CNTW'(NW)) begin
                  if (kind_ff == COEF_D) begin
                     src_ff   <= quo_ff[SW-1:0];
                     srem_ff  <= '0;
                     root_ff  <= '0;
                     cnt_ff   <= '0;
                     state_ff <= C_SQRT;
                  end else begin
                     value_ff <= -$signed(quo_ff[CW-1:0]);
                     done_ff  <= 1'b1;
                     state_ff <= C_IDLE;
                  end
               end else begin
                  rem_ff <= rem_in;
                  num_ff <= num_ff << 1;
                  quo_ff <= {quo_ff[NW-2:0], ge};
                  cnt_ff <= cnt_ff + CNTW'(1);
               end
            end
            C_SQRT: begin
               if (cnt_ff == CNTW'(RTW)) begin
                  value_ff <= -$signed(rp1[RTW:1]);
                  done_ff  <= 1'b1;
                  state_ff <= C_IDLE;
               end else begin
                  srem_ff <= sge ? sr_n - trial : sr_n;
                  root_ff <= {root_ff[RTW-2:0], sge};
                  src_ff  <= src_ff << 2;
                  cnt_ff  <= cnt_ff + CNTW'(1);
               end
            end
            default: begin
               state_ff <= C_IDLE;
            end
         endcase
      end
   end

endmodule

// File: design/sfw_back.sv
// ----------------------------------------------------------------------------
// sfw_back
// Walks the results of one job, fetches d and s, runs the twelve products
// through one multiplier, scales by the radius bit-serially, rounds and
// saturates into the output register.
// ----------------------------------------------------------------------------
module sfw_back #(
   parameter int COEF_BITS = sfw_pkg::COEF_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [sfw_pkg::RAD_W-1:0]   radius,
   input  logic                        job_valid,
   input  sfw_pkg::job_type            job,
   output logic                        pop,
   output sfw_pkg::coef_req_type       coef_req,
   input  logic                        coef_done,
   input  logic signed [COEF_BITS:0]   coef_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sfw_pkg::rsp_type            rsp_data
);
   import sfw_pkg::*;

   localparam int CW  = COEF_BITS + 1;
   localparam int PRW = CW + DATA_W;
   localparam int ACW = PRW + 2;
   localparam int SCW = ACW + RAD_W + 1;
   localparam int SHW = SCW - COEF_BITS;
   localparam logic signed [SCW-1:0] HALF = SCW'(1) <<< (COEF_BITS - 1);
   localparam logic signed [OUT_W-1:0] WMAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] WMIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef enum logic [2:0] {
      B_IDLE, B_SLOT, B_CD0, B_CD1, B_CS, B_MAC, B_SCALE, B_EMIT
   } state_type;

   state_type          state_ff;
   job_type            job_ff;
   logic [1:0]         slot_ff;
   logic [IDX_W-1:0]   rm_ff;
   logic [IDX_W:0]     rn_ff;
   req_type            b_ff, c_ff, a_ff;
   logic               last_ff;
   logic signed [CW-1:0] dn_ff, dn1_ff, s_ff;
   logic [1:0]         o_ff, j_ff, po_ff;
   logic               issue_done_ff, prod_vld_ff, pneg_ff;
   logic signed [PRW-1:0] prod_ff;
   logic signed [ACW-1:0] acc_ff [4];
   logic signed [SCW-1:0] scl_ff [4];
   logic [RAD_BIT_W-1:0] bit_ff;
   coef_req_type       coef_req_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               s_en, s_last;
   logic [IDX_W-1:0]   s_m;
   logic [IDX_W:0]     s_n;
   req_type            s_b, s_c, s_a;
   logic signed [CW-1:0]     csel;
   logic signed [DATA_W-1:0] opnd;
   logic                     neg;
   logic signed [PRW-1:0]    prod_in;
   logic signed [SCW-1:0]    scl_in [4];
   logic signed [SCW-1:0]    rnd [4];
   logic signed [OUT_W-1:0]  wind [4];

   function automatic logic signed [DATA_W-1:0] pick(input req_type v, input logic [1:0] idx);
      logic signed [DATA_W-1:0] r;
      case (idx)
         2'd0:    r = v.vort_re;
         2'd1:    r = v.vort_im;
         2'd2:    r = v.div_re;
         default: r = v.div_im;
      endcase
      return r;
   endfunction

   assign pop       = (state_ff == B_IDLE) && job_valid;
   assign coef_req  = coef_req_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // result slots of a job: (m,n-1), (m,n), (m,T), then the zero row (T,T)
   always_comb begin
      s_en   = 1'b0;
      s_m    = job_ff.m;
      s_n    = {1'b0, job_ff.n};
      s_b    = '0;
      s_c    = '0;
      s_a    = '0;
      s_last = 1'b0;
      case (slot_ff)
         2'd0: begin
            s_en   = job_ff.emit_prev;
            s_n    = {1'b0, job_ff.n} - (IDX_W+1)'(1);
            s_b    = job_ff.p2;
            s_c    = job_ff.p1;
            s_a    = job_ff.cur;
            s_last = !job_ff.row_end;
         end
         2'd1: begin
            s_en = job_ff.row_end;
            s_b  = job_ff.p1;
            s_c  = job_ff.cur;
         end
         2'd2: begin
            s_en   = job_ff.row_end;
            s_n    = {1'b0, job_ff.t};
            s_b    = job_ff.cur;
            s_last = !job_ff.zero_row;
         end
         default: begin
            s_en   = job_ff.row_end && job_ff.zero_row;
            s_m    = job_ff.t;
            s_n    = {1'b0, job_ff.t};
            s_last = 1'b1;
         end
      endcase
   end

   // term j of output o: j=0 d(n) on n-1, j=1 d(n+1) on n+1, j=2 s on n
   always_comb begin
      case (j_ff)
         2'd0: begin
            csel = dn_ff;
            opnd = pick(b_ff, o_ff);
            neg  = o_ff[1];
         end
         2'd1: begin
            csel = dn1_ff;
            opnd = pick(a_ff, o_ff);
            neg  = !o_ff[1];
         end
         default: begin
            csel = s_ff;
            opnd = pick(c_ff, 2'd3 - o_ff);
            neg  = !o_ff[0];
         end
      endcase
      prod_in = csel * opnd;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         scl_in[i] = (scl_ff[i] <<< 1) + (radius[bit_ff] ? SCW'(acc_ff[i]) : '0);
         rnd[i]    = scl_ff[i] + HALF;
         if ((rnd[i][SCW-1:OUT_W-1+COEF_BITS] == '0) ||
             (rnd[i][SCW-1:OUT_W-1+COEF_BITS] == '1)) begin
            wind[i] = rnd[i][OUT_W-1+COEF_BITS:COEF_BITS];
         end else begin
            wind[i] = rnd[i][SCW-1] ? WMIN : WMAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         slot_ff      <= '0;
         coef_req_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         prod_vld_ff  <= 1'b0;
      end else begin
         coef_req_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job;
                  slot_ff  <= '0;
                  state_ff <= B_SLOT;
               end
            end
            B_SLOT: begin
               if (s_en) begin
                  rm_ff       <= s_m;
                  rn_ff       <= s_n;
                  b_ff        <= s_b;
                  c_ff        <= s_c;
                  a_ff        <= s_a;
                  last_ff     <= s_last;
                  coef_req_ff <= '{start: 1'b1, kind: COEF_D, m: s_m, n: s_n};
                  state_ff    <= B_CD0;
               end else if (slot_ff == 2'd3) begin
                  state_ff <= B_IDLE;
               end else begin
                  slot_ff <= slot_ff + 2'd1;
               end
            end
            B_CD0: begin
               if (coef_done) begin
                  dn_ff       <= coef_value;
                  coef_req_ff <= '{start: 1'b1, kind: COEF_D, m: rm_ff,
                                   n: rn_ff + (IDX_W+1)'(1)};
                  state_ff    <= B_CD1;
               end
            end
            B_CD1: begin
               if (coef_done) begin
                  dn1_ff      <= coef_value;
                  coef_req_ff <= '{start: 1'b1, kind: COEF_S, m: rm_ff, n: rn_ff};
                  state_ff    <= B_CS;
               end
            end
            B_CS: begin
               if (coef_done) begin
                  s_ff          <= coef_value;
                  o_ff          <= '0;
                  j_ff          <= '0;
                  issue_done_ff <= 1'b0;
                  prod_vld_ff   <= 1'b0;
                  for (int i = 0; i < 4; i++) begin
                     acc_ff[i] <= '0;
                  end
                  state_ff <= B_MAC;
               end
            end
            B_MAC: begin
               // multiply stage registers its product for the accumulate stage in the next cycle
               prod_vld_ff <= 1'b0;
               if (!issue_done_ff) begin
                  prod_ff     <= prod_in;
                  pneg_ff     <= neg;
                  po_ff       <= o_ff;
                  prod_vld_ff <= 1'b1;
                  if (j_ff == 2'd2) begin
                     j_ff <= '0;
                     o_ff <= o_ff + 2'd1;
                     if (o_ff == 2'd3) begin
                        issue_done_ff <= 1'b1;
                     end
                  end else begin
                     j_ff <= j_ff + 2'd1;
                  end
               end
               if (prod_vld_ff) begin
                  acc_ff[po_ff] <= pneg_ff ? acc_ff[po_ff] - ACW'(prod_ff)
                                           : acc_ff[po_ff] + ACW'(prod_ff);
               end
               if (issue_done_ff && !prod_vld_ff) begin
                  for (int i = 0; i < 4; i++) begin
                     scl_ff[i] <= '0;
                  end
                  bit_ff   <= RAD_BIT_W'(RAD_W - 1);
                  state_ff <= B_SCALE;
               end
            end
            B_SCALE: begin
               for (int i = 0; i < 4; i++) begin
                  scl_ff[i] <= scl_in[i];
               end
               if (bit_ff == '0) begin
                  state_ff <= B_EMIT;
               end else begin
                  bit_ff <= bit_ff - RAD_BIT_W'(1);
               end
            end
            B_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.u_re        <= wind[0];
                  rsp_data_ff.u_im        <= wind[1];
                  rsp_data_ff.v_re        <= wind[2];
                  rsp_data_ff.v_im        <= wind[3];
                  rsp_data_ff.zonal_index <= rm_ff;
                  rsp_data_ff.total_index <= rn_ff[IDX_W-1:0];
                  rsp_data_ff.run_last    <= last_ff;
                  if (slot_ff == 2'd3) begin
                     state_ff <= B_IDLE;
                  end else begin
                     slot_ff  <= slot_ff + 2'd1;
                     state_ff <= B_SLOT;
                  end
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

endmodule

// File: design/spectral_vordiv_to_wind.sv
// Flow: an input beat is accepted while the job queue has room; the back end takes
//   the next job only when idle and then spends per result three coefficient
//   evaluations on one shared divider (plus a square root for each d), the
//   multiply/accumulate steps, the bit-serial radius scaling, emit and slot select.
// Results: (m,n-1) per beat with n > m; a row end adds (m,n), (m,T), last row also (T,T).
// Reset: field position (0,0), window zero, truncation 63, radius 6371229; no clearing pass.
// ----------------------------------------------------------------------------
// spectral_vordiv_to_wind
// Spectral vorticity/divergence to U/V wind coefficient converter, top level.
// ----------------------------------------------------------------------------
module spectral_vordiv_to_wind #(
   parameter int MAX_TRUNC = sfw_pkg::MAX_TRUNC_DEF,
   parameter int COEF_BITS = sfw_pkg::COEF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sfw_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sfw_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [sfw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sfw_pkg::RAD_W-1:0]     csr_wdata
);
   import sfw_pkg::*;

   logic [IDX_W-1:0]  trunc_ff;
   logic [RAD_W-1:0]  radius_ff;
   logic              restart;
   logic              push, q_full, q_valid, pop;
   job_type           push_job, head_job;
   logic [QLVL_W-1:0] q_level;
   coef_req_type      coef_req;
   logic              coef_done;
   logic signed [COEF_BITS:0] coef_value;

   assign restart = csr_we && (csr_index == CSR_TRUNC);

   always_ff @(posedge clock) begin
      if (reset) begin
         trunc_ff  <= TRUNC_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRUNC:  trunc_ff  <= csr_wdata[IDX_W-1:0];
            CSR_RADIUS: radius_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   sfw_front #(.MAX_TRUNC(MAX_TRUNC)) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .trunc     (trunc_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .job       (push_job)
   );

   sfw_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .job_in (push_job),
      .pop    (pop),
      .full   (q_full),
      .valid  (q_valid),
      .head   (head_job),
      .level  (q_level)
   );

   sfw_coef #(.COEF_BITS(COEF_BITS)) u_coef (
      .clock (clock),
      .reset (reset),
      .req   (coef_req),
      .done  (coef_done),
      .value (coef_value)
   );

   sfw_back #(.COEF_BITS(COEF_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .radius     (radius_ff),
      .job_valid  (q_valid),
      .job        (head_job),
      .pop        (pop),
      .coef_req   (coef_req),
      .coef_done  (coef_done),
      .coef_value (coef_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // every result lies in the triangle m <= n
   a_triangle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.zonal_index <= rsp_data.total_index)
      else $error("result outside the triangular spectrum");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= QLVL_W'(QDEPTH))
      else $error("job queue overfilled");

   // the queue only drains into an idle back end, and only when it holds a job
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("job taken from empty queue");

endmodule

// File: tb/wind_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wind_checker
// Watches the input, result and register ports of the wind converter, keeps
// its own copy of the field position, neighbour window and settings, works
// out the U/V coefficients of every accepted beat and compares each result
// beat in order, field by field.
// ----------------------------------------------------------------------------
module wind_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  sfw_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  sfw_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [sfw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sfw_pkg::RAD_W-1:0]     csr_wdata,
   output int                            fail_count,
   output int                            outstanding
);
   import sfw_pkg::*;

   typedef logic signed [127:0] wide_type;

   localparam int MAX_T = MAX_TRUNC_DEF;
   localparam int CB    = COEF_BITS_DEF;

   rsp_type     wind_due[$];
   logic [6:0]  trunc_reg;
   logic [23:0] radius_reg;
   int          zonal_pos;
   int          total_pos;
   req_type     prev1;
   req_type     prev2;

   assign outstanding = wind_due.size();

   function automatic wide_type d_coef(int m, int n);
      logic [127:0] a, rhs, lo, hi, mid, t, lhs;
      if (n == 0 || n <= m) return '0;
      a   = 128'((4 * n * n - 1) * n * n);
      rhs = 128'(4 * (n * n - m * m)) << (2 * CB);
      lo  = '0;
      hi  = 128'd1 << CB;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         t   = 2 * mid - 1;
         lhs = t * t * a;
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return -$signed(lo);
   endfunction

   function automatic wide_type s_coef(int m, int n);
      logic [127:0] den;
      if (m == 0 || n == 0) return '0;
      den = 128'(n * (n + 1));
      return -$signed(((128'(m) << CB) + den / 2) / den);
   endfunction

   function automatic logic signed [47:0] scale_sat(wide_type x);
      wide_type p, sh;
      wide_type rr;
      rr = wide_type'({104'd0, radius_reg});
      p  = x * rr + (wide_type'(1) <<< (CB - 1));
      sh = p >>> CB;
      if (sh > wide_type'(48'sh7FFF_FFFF_FFFF)) return 48'sh7FFF_FFFF_FFFF;
      if (sh < -(wide_type'(1) <<< 47)) return 48'sh8000_0000_0000;
      return sh[47:0];
   endfunction

   function automatic wide_type sx(logic signed [31:0] v);
      return wide_type'(v);
   endfunction

   // b, c, a are the n-1, n and n+1 neighbours of output (m,n)
   function automatic void push_wind(int m, int n, req_type b, req_type c, req_type a,
                                     logic last);
      wide_type dn, dn1, s;
      rsp_type  r;
      dn  = d_coef(m, n);
      dn1 = d_coef(m, n + 1);
      s   = s_coef(m, n);
      r.u_re = scale_sat(dn * sx(b.vort_re) - dn1 * sx(a.vort_re) - s * sx(c.div_im));
      r.u_im = scale_sat(dn * sx(b.vort_im) - dn1 * sx(a.vort_im) + s * sx(c.div_re));
      r.v_re = scale_sat(-dn * sx(b.div_re) + dn1 * sx(a.div_re) - s * sx(c.vort_im));
      r.v_im = scale_sat(-dn * sx(b.div_im) + dn1 * sx(a.div_im) + s * sx(c.vort_re));
      r.zonal_index = m[6:0];
      r.total_index = n[6:0];
      r.run_last    = last;
      wind_due.push_back(r);
   endfunction

   function automatic void restart_field();
      zonal_pos = 0;
      total_pos = 0;
      prev1 = '0;
      prev2 = '0;
   endfunction

   function automatic void take_coeff(req_type cur);
      int      t, m, n;
      logic    row_end;
      req_type p1, p2;
      t = trunc_reg;
      if (t < 2) t = 2;
      if (t > MAX_T) t = MAX_T;
      if (zonal_pos > t - 1 || total_pos > t - 1 || total_pos < zonal_pos) restart_field();
      m = zonal_pos;
      n = total_pos;
      row_end = (n == t - 1);
      p1 = (n > m) ? prev1 : '0;
      p2 = (n > m + 1) ? prev2 : '0;
      if (n > m) push_wind(m, n - 1, p2, p1, cur, !row_end);
      if (row_end) begin
         push_wind(m, n, p1, cur, '0, 1'b0);
         push_wind(m, t, cur, '0, '0, m != t - 1);
         if (m == t - 1) push_wind(t, t, '0, '0, '0, 1'b1);
      end
      prev2 = prev1;
      prev1 = cur;
      if (row_end) begin
         zonal_pos = (m == t - 1) ? 0 : m + 1;
         total_pos = zonal_pos;
      end else begin
         total_pos = n + 1;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         trunc_reg  <= TRUNC_RESET;
         radius_reg <= RADIUS_RESET;
         restart_field();
         wind_due.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (wind_due.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result beat: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = wind_due.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch\n  expected %p\n  actual   %p", want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_TRUNC) begin
               trunc_reg <= csr_wdata[6:0];
               restart_field();
            end else if (csr_index == CSR_RADIUS) begin
               radius_reg <= csr_wdata;
            end
         end
         if (req_valid && req_ready) take_coeff(req_data);
      end
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives spectral coefficient beats through the converter under several
// truncation and radius settings, with bursty input and a stalling receiver;
// the checker does the predicting and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import sfw_pkg::*;

   localparam int N_ITEMS   = 230;
   localparam int SETTLE    = 1200;
   localparam int MAX_CYCLE = 4000000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TRUNC;
   logic [RAD_W-1:0]     csr_wdata = '0;
   int                   fail_count;
   int                   outstanding;
   int                   cycle     = 0;
   int                   sent      = 0;
   int                   burst_left = 1;
   int                   stall_mode = 0;

   always #6 clock = ~clock;

   spectral_vordiv_to_wind i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   wind_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .outstanding
   );

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle == MAX_CYCLE) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: ready pattern drawn at random from four modes
   always @(posedge clock) begin
      if (cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= (cycle % 5 != 0);
      endcase
   end

   function automatic logic [31:0] coeff_val();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         4: return 32'($signed($urandom_range(0, 131072)) - 65536);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_beat();
      req_type r;
      r.vort_re = coeff_val();
      r.vort_im = coeff_val();
      r.div_re  = coeff_val();
      r.div_im  = coeff_val();
      return r;
   endfunction

   task automatic send_beat(input req_type d);
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [RAD_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_trunc(input int t);
      write_reg(CSR_TRUNC, {17'($urandom), 7'(t)});
   endtask

   task automatic send_fixed(input logic [31:0] v, input int count);
      req_type r;
      r = {v, ~v, v, ~v};
      repeat (count) send_beat(r);
   endtask

   initial begin
      int t, count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, then small fields at extreme settings
      send_fixed(32'h7FFF_FFFF, 2);
      send_fixed(32'h8000_0000, 2);
      wait_idle();
      write_trunc(2);
      write_reg(CSR_RADIUS, 24'hFF_FFFF);
      send_fixed(32'h7FFF_FFFF, 3);
      send_fixed(32'h8000_0000, 3);
      wait_idle();
      // zero radius
      write_reg(CSR_RADIUS, 24'd0);
      write_trunc(3);
      send_fixed(32'h0001_0000, 6);
      wait_idle();
      // truncation below range clamps to 2
      write_reg(CSR_RADIUS, 24'd1);
      write_reg(CSR_TRUNC, 24'hFF_FF80);
      send_fixed(32'hFFFF_FFFF, 3);
      wait_idle();
      write_trunc(1);
      send_fixed(32'h0000_0001, 3);
      wait_idle();
      write_trunc(127);
      write_reg(CSR_RADIUS, 24'd6371229);
      send_fixed(32'h1234_5678, 3);
      wait_idle();

      while (sent < N_ITEMS) begin
         case ($urandom_range(0, 9))
            0: t = 127;
            1, 2: t = $urandom_range(7, 20);
            3: t = $urandom_range(0, 127);
            default: t = $urandom_range(2, 6);
         endcase
         write_trunc(t);
         case ($urandom_range(0, 3))
            0: write_reg(CSR_RADIUS, 24'hFF_FFFF);
            1: write_reg(CSR_RADIUS, 24'd1);
            2: write_reg(CSR_RADIUS, 24'd6371229);
            default: write_reg(CSR_RADIUS, RAD_W'($urandom_range(1, 24'hFF_FFFF)));
         endcase
         if (t < 2) t = 2;
         if (t <= 8 && $urandom_range(0, 3) != 0)
            count = (t * (t + 1) / 2) * $urandom_range(1, 2);
         else
            count = $urandom_range(5, 30);
         repeat (count) send_beat(rand_beat());
         wait_idle();
      end

      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
